@@ design/mhw_pkg.sv @@
// ----------------------------------------------------------------------------
// mhw_pkg
// shared types, register map, reset values and lookup functions of the
// multi-channel heartbeat watchdog
// ----------------------------------------------------------------------------
package mhw_pkg;

   // field widths
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int TIMEOUT_BITS   = 16;
   localparam int MASK_BITS      = 10;
   localparam int CHAN_BITS      = 4;
   localparam int COUNT_BITS     = 4;
   localparam int BLINK_BITS     = 6;
   localparam int PRIO_BITS      = 4;

   // operation codes
   localparam logic [1:0] FUNC_HEARTBEAT = 2'd0;
   localparam logic [1:0] FUNC_TICK      = 2'd1;
   localparam logic [1:0] FUNC_SCAN      = 2'd2;

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] REG_REMOTE_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MOTOR_TIMEOUT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENABLE_MASK    = 2'd2;

   // reset values
   localparam logic [TIMEOUT_BITS-1:0] REMOTE_TIMEOUT_RST = 16'd100;
   localparam logic [TIMEOUT_BITS-1:0] MOTOR_TIMEOUT_RST  = 16'd200;
   localparam logic [MASK_BITS-1:0]    ENABLE_MASK_RST    = 10'h3FF;

   localparam logic [BLINK_BITS-1:0] BLINK_WRAP = 6'd50;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 4'd15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // running scan result
   typedef struct packed {
      logic [MASK_BITS-1:0]  mask;
      logic [COUNT_BITS-1:0] count;
      logic [PRIO_BITS-1:0]  best;
      logic [CHAN_BITS-1:0]  top;
   } scan_acc_type;

   function automatic logic [PRIO_BITS-1:0] chan_priority(input logic [CHAN_BITS-1:0] ch);
      logic [PRIO_BITS-1:0] prio;
      unique case (ch)
         4'd0:    prio = 4'd10;
         4'd1:    prio = 4'd10;
         4'd2:    prio = 4'd9;
         4'd3:    prio = 4'd8;
         4'd4:    prio = 4'd2;
         4'd5:    prio = 4'd3;
         4'd6:    prio = 4'd4;
         4'd7:    prio = 4'd5;
         4'd8:    prio = 4'd6;
         4'd9:    prio = 4'd7;
         default: prio = 4'd1;
      endcase
      return prio;
   endfunction

   function automatic logic pulse_hit(input logic [CHAN_BITS-1:0]  top,
                                      input logic [BLINK_BITS-1:0] cnt);
      logic hit;
      unique case (top)
         4'd0:    hit = (cnt == 6'd1);
         4'd2:    hit = (cnt == 6'd1) || (cnt == 6'd7);
         4'd1:    hit = (cnt == 6'd1) || (cnt == 6'd7) || (cnt == 6'd13);
         4'd3:    hit = (cnt == 6'd1) || (cnt == 6'd7) || (cnt == 6'd13) || (cnt == 6'd19);
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

@@ design/mhw_stamp_ram.sv @@
// ----------------------------------------------------------------------------
// mhw_stamp_ram
// last-heard timestamp store: one write port, one registered read port,
// per-entry valid bits so unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
module mhw_stamp_ram #(
   parameter int DEPTH     = 10,
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] stamp_mem_ff [DEPTH];
   logic [DEPTH-1:0] entry_vld_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stamp_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= entry_vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

@@ design/multi_channel_heartbeat_watchdog_unit.sv @@
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_unit
// per-channel heartbeat timeout watchdog with priority alert pattern
// ----------------------------------------------------------------------------
//
//  port group  direction  handshake            beat contents
//  req_*       in         req_valid/req_ready  func, channel
//  rsp_*       out        rsp_valid/rsp_ready  offline mask, count, fault, top, pulse
//  csr_*       in         csr_write only       register index, write data
//
//  heartbeat and tick beats are accepted back to back
//  a scan beat walks the timestamp memory, which has one read port, so the
//  walk reads one channel per cycle; then a drain state empties the compare
//  stage and a finish state loads the result register
//  reset is synchronous; per-entry valid bits make every timestamp read as
//  zero right away, so no clearing pass is needed
//  a finished scan waits in its last state while an older result is stalled;
//  the result register frees the input side as soon as it is loaded
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog_unit #(
   parameter int CHANNELS  = 10,
   parameter int TIME_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input beats
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_func,
   input  logic [mhw_pkg::CHAN_BITS-1:0]          req_channel,
   // result beats
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mhw_pkg::MASK_BITS-1:0]          rsp_offline_mask,
   output logic [mhw_pkg::COUNT_BITS-1:0]         rsp_offline_count,
   output logic                                   rsp_fault_valid,
   output logic [mhw_pkg::CHAN_BITS-1:0]          rsp_top_channel,
   output logic                                   rsp_alert_pulse,
   // register writes
   input  logic                                   csr_write,
   input  logic [mhw_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mhw_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CHANNELS - 1);
   localparam int EN_PAD = (1 << mhw_pkg::CHAN_BITS) - mhw_pkg::MASK_BITS;

   // control state
   mhw_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [mhw_pkg::TIMEOUT_BITS-1:0] remote_timeout_ff;
   logic [mhw_pkg::TIMEOUT_BITS-1:0] motor_timeout_ff;
   logic [mhw_pkg::MASK_BITS-1:0]    enable_mask_ff;
   logic [(1 << mhw_pkg::CHAN_BITS)-1:0] enable_wide;

   // clock and blink state
   logic [TIME_BITS-1:0]             time_now_ff;
   logic [mhw_pkg::BLINK_BITS-1:0]   blink_ff;
   logic [mhw_pkg::BLINK_BITS-1:0]   blink_inc;
   logic [mhw_pkg::BLINK_BITS-1:0]   blink_in;

   // scan walk
   logic [IDX_BITS-1:0]  scan_idx_ff;
   logic [IDX_BITS-1:0]  rd_idx_ff;
   logic                 rd_go_ff;
   logic                 rd_en;
   logic                 scan_start;
   logic                 out_load;
   logic [TIME_BITS-1:0] stamp;

   // compare stage
   logic [mhw_pkg::CHAN_BITS-1:0] cmp_chan;
   logic [TIME_BITS-1:0]          elapsed;
   logic [TIME_BITS-1:0]          limit;
   logic                          cmp_offline;
   logic [mhw_pkg::PRIO_BITS-1:0] cmp_prio;
   mhw_pkg::scan_acc_type         acc_ff;

   // heartbeat stamping
   logic req_fire;
   logic hb_wr;

   // result register
   logic                              rsp_valid_ff;
   logic [mhw_pkg::MASK_BITS-1:0]     rsp_mask_ff;
   logic [mhw_pkg::COUNT_BITS-1:0]    rsp_count_ff;
   logic                              rsp_fault_ff;
   logic [mhw_pkg::CHAN_BITS-1:0]     rsp_top_ff;
   logic                              rsp_pulse_ff;

   assign enable_wide = {{EN_PAD{1'b0}}, enable_mask_ff};
   assign req_fire    = req_valid && req_ready;
   // heartbeat to a channel beyond the table or a disabled one is dropped
   assign hb_wr = req_fire && (req_func == mhw_pkg::FUNC_HEARTBEAT)
                  && (32'(req_channel) < 32'(CHANNELS)) && enable_wide[req_channel];

   mhw_stamp_ram #(
      .DEPTH     (CHANNELS),
      .WIDTH     (TIME_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_stamp_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hb_wr),
      .wr_addr (IDX_BITS'(req_channel)),
      .wr_data (time_now_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (stamp)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and strobes
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      scan_start = 1'b0;
      rd_en      = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         mhw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_func == mhw_pkg::FUNC_SCAN)) begin
               scan_start = 1'b1;
               state_in   = mhw_pkg::ST_SCAN;
            end
         end
         mhw_pkg::ST_SCAN: begin
            rd_en = 1'b1;
            if (scan_idx_ff == LAST_IDX) begin
               state_in = mhw_pkg::ST_DRAIN;
            end
         end
         mhw_pkg::ST_DRAIN: begin
            state_in = mhw_pkg::ST_FINISH;
         end
         mhw_pkg::ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = mhw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhw_pkg::ST_IDLE;
         end
      endcase
   end

   // configuration writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         remote_timeout_ff <= mhw_pkg::REMOTE_TIMEOUT_RST;
         motor_timeout_ff  <= mhw_pkg::MOTOR_TIMEOUT_RST;
         enable_mask_ff    <= mhw_pkg::ENABLE_MASK_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            mhw_pkg::REG_REMOTE_TIMEOUT: remote_timeout_ff <= csr_data;
            mhw_pkg::REG_MOTOR_TIMEOUT:  motor_timeout_ff  <= csr_data;
            mhw_pkg::REG_ENABLE_MASK:    enable_mask_ff    <= csr_data[mhw_pkg::MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // millisecond counter, wraps freely
   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff <= '0;
      end else if (req_fire && (req_func == mhw_pkg::FUNC_TICK)) begin
         time_now_ff <= time_now_ff + TIME_BITS'(1);
      end
   end

   // walk index and read pipeline tag
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_go_ff <= 1'b0;
      end else begin
         rd_go_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_start) begin
         scan_idx_ff <= '0;
      end else if (rd_en) begin
         scan_idx_ff <= scan_idx_ff + IDX_BITS'(1);
      end
      if (rd_en) begin
         rd_idx_ff <= scan_idx_ff;
      end
   end

   // compare of the entry that just came back from memory
   always_comb begin
      cmp_chan    = mhw_pkg::CHAN_BITS'(rd_idx_ff);
      elapsed     = time_now_ff - stamp;
      limit       = (rd_idx_ff == '0) ? TIME_BITS'(remote_timeout_ff)
                                      : TIME_BITS'(motor_timeout_ff);
      cmp_offline = enable_wide[cmp_chan] && (elapsed > limit);
      cmp_prio    = mhw_pkg::chan_priority(cmp_chan);
   end

   // running mask, count and best priority; strict compare keeps lower index
   always_ff @(posedge clock) begin
      if (scan_start) begin
         acc_ff <= '0;
      end else if (rd_go_ff && cmp_offline) begin
         acc_ff.mask <= acc_ff.mask
                        | (mhw_pkg::MASK_BITS'(1) << cmp_chan);
         if (acc_ff.count != mhw_pkg::COUNT_MAX) begin
            acc_ff.count <= acc_ff.count + mhw_pkg::COUNT_BITS'(1);
         end
         if (cmp_prio > acc_ff.best) begin
            acc_ff.best <= cmp_prio;
            acc_ff.top  <= cmp_chan;
         end
      end
   end

   // blink counter steps only on scans that find a fault
   assign blink_inc = blink_ff + mhw_pkg::BLINK_BITS'(1);
   assign blink_in  = (blink_inc > mhw_pkg::BLINK_WRAP) ? '0 : blink_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_ff <= '0;
      end else if (out_load && (acc_ff.count != '0)) begin
         blink_ff <= blink_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_mask_ff  <= acc_ff.mask;
         rsp_count_ff <= acc_ff.count;
         rsp_fault_ff <= (acc_ff.count != '0);
         rsp_top_ff   <= acc_ff.top;
         rsp_pulse_ff <= (acc_ff.count != '0) && mhw_pkg::pulse_hit(acc_ff.top, blink_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_offline_mask  = rsp_mask_ff;
   assign rsp_offline_count = rsp_count_ff;
   assign rsp_fault_valid   = rsp_fault_ff;
   assign rsp_top_channel   = rsp_top_ff;
   assign rsp_alert_pulse   = rsp_pulse_ff;

   // blink counter stays within its wrap range
   a_blink_range: assert property (@(posedge clock) disable iff (reset)
      blink_ff <= mhw_pkg::BLINK_WRAP)
      else $error("blink counter out of range");

   // reported count agrees with the mask
   a_count_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones(rsp_mask_ff) == 32'(rsp_count_ff)))
      else $error("offline count does not match mask");

   // fault flag agrees with the count
   a_fault_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_fault_ff == (rsp_count_ff != '0)))
      else $error("fault flag does not match count");

   // reported top channel is one of the offline channels
   a_top_in_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff)
      |-> (((rsp_mask_ff >> rsp_top_ff) & mhw_pkg::MASK_BITS'(1)) != '0))
      else $error("top channel not offline");

   // a pulse only comes with a fault
   a_pulse_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pulse_ff) |-> rsp_fault_ff)
      else $error("alert pulse without fault");

endmodule

@@ tb/sv/mhw_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mhw_tb_pkg
// scan report type and scoreboard for the heartbeat watchdog bench
// ----------------------------------------------------------------------------
package mhw_tb_pkg;

   localparam int          CHANNEL_COUNT    = 10;
   localparam int unsigned REPORT_LOG_LIMIT = 10;
   localparam logic [5:0]  BLINK_TOP        = 6'd50;

   typedef struct packed {
      logic [mhw_pkg::MASK_BITS-1:0]  offline_mask;
      logic [mhw_pkg::COUNT_BITS-1:0] offline_count;
      logic                           fault_valid;
      logic [mhw_pkg::CHAN_BITS-1:0]  top_channel;
      logic                           alert_pulse;
   } scan_report_type;

   class watchdog_scoreboard;
      logic [31:0]                   ms_now;
      logic [31:0]                   heard_at [CHANNEL_COUNT];
      logic [5:0]                    blink_phase;
      logic [15:0]                   remote_limit;
      logic [15:0]                   motor_limit;
      logic [mhw_pkg::MASK_BITS-1:0] enables;
      int unsigned                   rank [CHANNEL_COUNT];
      scan_report_type               reports_due [$];
      int unsigned                   failures;

      function new();
         rank = '{10, 10, 9, 8, 2, 3, 4, 5, 6, 7};
         ms_now = '0;
         foreach (heard_at[i]) heard_at[i] = '0;
         blink_phase = '0;
         remote_limit = mhw_pkg::REMOTE_TIMEOUT_RST;
         motor_limit = mhw_pkg::MOTOR_TIMEOUT_RST;
         enables = mhw_pkg::ENABLE_MASK_RST;
         failures = 0;
      endfunction

      function void write_reg(logic [mhw_pkg::CSR_INDEX_BITS-1:0] idx,
                              logic [mhw_pkg::CSR_DATA_BITS-1:0]  data);
         unique case (idx)
            mhw_pkg::REG_REMOTE_TIMEOUT: remote_limit = data;
            mhw_pkg::REG_MOTOR_TIMEOUT:  motor_limit = data;
            mhw_pkg::REG_ENABLE_MASK:    enables = data[mhw_pkg::MASK_BITS-1:0];
            default: ;
         endcase
      endfunction

      // one offline scan over all channels, advancing the blink phase on a fault
      function scan_report_type predict_scan();
         scan_report_type r;
         int unsigned     best;
         logic [31:0]     elapsed;
         logic [15:0]     limit;
         int unsigned     bursts;
         r = '0;
         best = 0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            elapsed = ms_now - heard_at[i];
            limit = (i == 0) ? remote_limit : motor_limit;
            if (enables[i] && elapsed > {16'd0, limit}) begin
               r.offline_mask[i] = 1'b1;
               r.offline_count = r.offline_count + 1'b1;
               if (rank[i] > best) begin
                  best = rank[i];
                  r.top_channel = mhw_pkg::CHAN_BITS'(i);
               end
            end
         end
         if (r.offline_count != 0) begin
            r.fault_valid = 1'b1;
            blink_phase = (blink_phase >= BLINK_TOP) ? 6'd0 : blink_phase + 6'd1;
            // pulses sit at 1, 7, 13, 19; the top channel decides how many of them
            unique case (r.top_channel)
               4'd0:    bursts = 1;
               4'd1:    bursts = 3;
               4'd2:    bursts = 2;
               4'd3:    bursts = 4;
               default: bursts = 0;
            endcase
            r.alert_pulse = (blink_phase % 6 == 1) && (blink_phase / 6 < bursts);
         end
         return r;
      endfunction

      function void note_beat(logic [1:0] func, logic [mhw_pkg::CHAN_BITS-1:0] ch);
         unique case (func)
            mhw_pkg::FUNC_HEARTBEAT: begin
               if (ch < CHANNEL_COUNT && enables[ch]) heard_at[ch] = ms_now;
            end
            mhw_pkg::FUNC_TICK:      ms_now = ms_now + 32'd1;
            mhw_pkg::FUNC_SCAN:      reports_due.push_back(predict_scan());
            default: ;
         endcase
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= REPORT_LOG_LIMIT) $display("%0t mismatch: %s", $time, msg);
      endfunction

      function void check_scan_report(scan_report_type got);
         scan_report_type want;
         if (reports_due.size() == 0) begin
            flag($sformatf("result beat with no scan pending, mask %h", got.offline_mask));
            return;
         end
         want = reports_due.pop_front();
         if (got.offline_mask !== want.offline_mask)
            flag($sformatf("offline_mask expected %h got %h",
                           want.offline_mask, got.offline_mask));
         if (got.offline_count !== want.offline_count)
            flag($sformatf("offline_count expected %0d got %0d",
                           want.offline_count, got.offline_count));
         if (got.fault_valid !== want.fault_valid)
            flag($sformatf("fault_valid expected %b got %b",
                           want.fault_valid, got.fault_valid));
         if (got.top_channel !== want.top_channel)
            flag($sformatf("top_channel expected %0d got %0d",
                           want.top_channel, got.top_channel));
         if (got.alert_pulse !== want.alert_pulse)
            flag($sformatf("alert_pulse expected %b got %b",
                           want.alert_pulse, got.alert_pulse));
      endfunction

      function int unsigned pending();
         return reports_due.size();
      endfunction

      function void close_out();
         repeat (reports_due.size()) flag("scan report never arrived");
         reports_due.delete();
      endfunction
   endclass

endpackage

@@ tb/sv/tb_multi_channel_heartbeat_watchdog_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_channel_heartbeat_watchdog_unit
// self-checking bench: heartbeat, tick and scan beats go in under several
// timeout and enable settings; every scan report is checked field by field
// against a scoreboard that tracks the timestamps and the blink phase
// ----------------------------------------------------------------------------
module tb_multi_channel_heartbeat_watchdog_unit;

   // codes the design package leaves unnamed
   localparam logic [1:0]                         FUNC_SPARE = 2'd3;
   localparam logic [mhw_pkg::CSR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

   localparam int DRAIN_CYCLES = 20;   // idle margin after the last scan report
   localparam int PHASE_BEATS  = 120;
   localparam int LIMIT_TICKS  = 30;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [1:0]                         req_func;
   logic [mhw_pkg::CHAN_BITS-1:0]      req_channel;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [mhw_pkg::MASK_BITS-1:0]      rsp_offline_mask;
   logic [mhw_pkg::COUNT_BITS-1:0]     rsp_offline_count;
   logic                               rsp_fault_valid;
   logic [mhw_pkg::CHAN_BITS-1:0]      rsp_top_channel;
   logic                               rsp_alert_pulse;
   logic                               csr_write;
   logic [mhw_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [mhw_pkg::CSR_DATA_BITS-1:0]  csr_data;

   // no random idling on either side while set
   bit calm = 1'b0;

   mhw_tb_pkg::watchdog_scoreboard sb = new();
   mhw_tb_pkg::scan_report_type    seen;

   multi_channel_heartbeat_watchdog_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_channel       (req_channel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_offline_mask  (rsp_offline_mask),
      .rsp_offline_count (rsp_offline_count),
      .rsp_fault_valid   (rsp_fault_valid),
      .rsp_top_channel   (rsp_top_channel),
      .rsp_alert_pulse   (rsp_alert_pulse),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   function automatic bit take_gap();
      return !calm && ($urandom_range(0, 99) < 7);
   endfunction

   // result side stalls now and then, decided at each falling edge
   always @(negedge clock) begin
      rsp_ready <= !take_gap();
   end

   // everything is observed at the rising edge, before the design updates
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_beat(req_func, req_channel);
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_offline_mask, rsp_offline_count, rsp_fault_valid,
                    rsp_top_channel, rsp_alert_pulse};
            sb.check_scan_report(seen);
         end
      end
   end

   // one input beat; valid stays up from one beat to the next unless a gap is taken
   task automatic send_beat(input logic [1:0] func,
                            input logic [mhw_pkg::CHAN_BITS-1:0] ch);
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_channel <= ch;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // input side goes quiet until every scan report is back and the block is idle
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // full register setting, with junk in the unused enable bits and a write
   // to the unused index that must change nothing
   task automatic apply_setting(input logic [15:0] remote, input logic [15:0] motor,
                                input logic [mhw_pkg::MASK_BITS-1:0] enable);
      settle();
      csr_write <= 1'b1;
      csr_index <= mhw_pkg::REG_REMOTE_TIMEOUT;
      csr_data <= remote;
      @(negedge clock);
      csr_index <= mhw_pkg::REG_MOTOR_TIMEOUT;
      csr_data <= motor;
      @(negedge clock);
      csr_index <= mhw_pkg::REG_ENABLE_MASK;
      csr_data <= {6'($urandom), enable};
      @(negedge clock);
      csr_index <= REG_UNUSED;
      csr_data <= 16'($urandom);
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // random mix: heartbeats keep channels alive, ticks age them, scans report;
   // ignored beats (spare code, stray or disabled channel) are not counted
   task automatic random_beats(input int unsigned n);
      int unsigned                   counted;
      int unsigned                   pick;
      logic [mhw_pkg::CHAN_BITS-1:0] ch;
      counted = 0;
      while (counted < n) begin
         pick = $urandom_range(0, 99);
         ch = ($urandom_range(0, 99) < 88)
              ? mhw_pkg::CHAN_BITS'($urandom_range(0, 9))
              : mhw_pkg::CHAN_BITS'($urandom_range(10, 15));
         if (pick < 3) begin
            send_beat(FUNC_SPARE, mhw_pkg::CHAN_BITS'($urandom));
         end else if (pick < 38) begin
            send_beat(mhw_pkg::FUNC_HEARTBEAT, ch);
            if (ch < mhw_tb_pkg::CHANNEL_COUNT && sb.enables[ch]) counted++;
         end else if (pick < 76) begin
            send_beat(mhw_pkg::FUNC_TICK, mhw_pkg::CHAN_BITS'($urandom));
            counted++;
         end else begin
            send_beat(mhw_pkg::FUNC_SCAN, mhw_pkg::CHAN_BITS'($urandom));
            counted++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = mhw_pkg::FUNC_HEARTBEAT;
      req_channel = '0;
      csr_write = 1'b0;
      csr_index = mhw_pkg::REG_REMOTE_TIMEOUT;
      csr_data = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset setting: clean scan at time zero, spare code, heartbeats
      // to channels that do not exist and to channel 9, a tick and a second scan
      send_beat(mhw_pkg::FUNC_SCAN, 4'd0);
      send_beat(FUNC_SPARE, 4'd5);
      send_beat(mhw_pkg::FUNC_HEARTBEAT, 4'd15);
      send_beat(mhw_pkg::FUNC_HEARTBEAT, 4'd10);
      send_beat(mhw_pkg::FUNC_HEARTBEAT, 4'd9);
      send_beat(mhw_pkg::FUNC_TICK, 4'd0);
      send_beat(mhw_pkg::FUNC_SCAN, 4'd0);

      // directed, zero remote timeout: everything falls offline, then the priority
      // channels are heard in pairs and ticks age them out again, so the top moves
      apply_setting(16'd0, 16'd1, 10'h3FF);
      send_beat(mhw_pkg::FUNC_TICK, 4'd0);
      send_beat(mhw_pkg::FUNC_TICK, 4'd0);
      send_beat(mhw_pkg::FUNC_SCAN, 4'd0);
      send_beat(mhw_pkg::FUNC_HEARTBEAT, 4'd0);
      send_beat(mhw_pkg::FUNC_HEARTBEAT, 4'd1);
      send_beat(mhw_pkg::FUNC_SCAN, 4'd0);
      send_beat(mhw_pkg::FUNC_TICK, 4'd0);
      send_beat(mhw_pkg::FUNC_SCAN, 4'd0);
      send_beat(mhw_pkg::FUNC_HEARTBEAT, 4'd2);
      send_beat(mhw_pkg::FUNC_HEARTBEAT, 4'd3);
      send_beat(mhw_pkg::FUNC_TICK, 4'd0);
      send_beat(mhw_pkg::FUNC_TICK, 4'd0);
      send_beat(mhw_pkg::FUNC_SCAN, 4'd15);
      send_beat(FUNC_SPARE, 4'd15);

      // random phases over a spread of settings; the first one runs with no idling
      calm = 1'b1;
      apply_setting(16'd0, 16'd0, 10'h3FF);
      random_beats(PHASE_BEATS);
      calm = 1'b0;
      apply_setting(16'd3, 16'd7, 10'h3FF);
      random_beats(PHASE_BEATS);
      apply_setting(16'd0, 16'hFFFF, 10'h3FF);
      random_beats(PHASE_BEATS);
      apply_setting(16'hFFFF, 16'd2, 10'h3FF);
      random_beats(PHASE_BEATS);
      apply_setting(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                    mhw_pkg::MASK_BITS'($urandom));
      random_beats(PHASE_BEATS);
      // nothing enabled: no stamps, never offline
      apply_setting(16'd5, 16'd5, 10'h000);
      random_beats(PHASE_BEATS);
      // priority channels off, so the low-priority ones reach the top
      apply_setting(16'd1, 16'd4, 10'h3F0);
      random_beats(PHASE_BEATS);
      apply_setting(16'd2, 16'd12, 10'h00F);
      random_beats(PHASE_BEATS);
      apply_setting(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                    mhw_pkg::MASK_BITS'($urandom));
      random_beats(PHASE_BEATS);

      // equal timeouts: elapsed equal to the limit is still online, one more
      // tick takes all ten channels offline at once
      apply_setting(16'(LIMIT_TICKS), 16'(LIMIT_TICKS), 10'h3FF);
      for (int c = 0; c < mhw_tb_pkg::CHANNEL_COUNT; c++) begin
         send_beat(mhw_pkg::FUNC_HEARTBEAT, mhw_pkg::CHAN_BITS'(c));
      end
      repeat (LIMIT_TICKS) send_beat(mhw_pkg::FUNC_TICK, 4'd0);
      send_beat(mhw_pkg::FUNC_SCAN, 4'd0);
      send_beat(mhw_pkg::FUNC_TICK, 4'd0);
      send_beat(mhw_pkg::FUNC_SCAN, 4'd0);

      // wind down: wait for outstanding reports, bounded, then let the block rest
      req_valid <= 1'b0;
      for (int k = 0; k < 5000 && sb.pending() != 0; k++) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      sb.close_out();
      if (sb.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ sim.f @@
design/mhw_pkg.sv
design/mhw_stamp_ram.sv
design/multi_channel_heartbeat_watchdog_unit.sv
tb/sv/mhw_tb_pkg.sv
tb/sv/tb_multi_channel_heartbeat_watchdog_unit.sv
